// ===== hw/rtl/msfc_pkg.sv =====
package msfc_pkg;

  localparam int MAX_VIEWS  = 8;
  localparam int MAX_MODELS = 4;

  localparam int VIEW_W  = (MAX_VIEWS > 1) ? $clog2(MAX_VIEWS) : 1;
  localparam int VCNT_W  = $clog2(MAX_VIEWS + 1);
  localparam int MODEL_W = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1;
  localparam int MCNT_W  = $clog2(MAX_MODELS + 1);

  localparam int ID_W     = 3;
  localparam int CLS_W    = 3;
  localparam int POS_W    = 16;
  localparam int SCORE_W  = 16;
  localparam int WEIGHT_W = 24;
  localparam int SUM_W    = 48;
  localparam int WSUM_W   = 32;
  localparam int SQ_W     = 2 * POS_W;
  localparam int PROD_W   = SCORE_W + WEIGHT_W;

  // restoring divider (48 / 32) and bit-pair square root
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = 24;
  localparam int STEP_W     = 6;
  localparam logic [SUM_W-1:0] W_DIVIDEND = SUM_W'(1) << 46;
  localparam logic [SUM_W-1:0] SQRT_BIT0  = SUM_W'(1) << 46;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR0 = 3'd1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ,
    OP_W_ZERO,
    OP_DIV_INIT_W,
    OP_DIV_INIT_F,
    OP_DIV_STEP,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_W_ROOT,
    OP_MUL,
    OP_ACC,
    OP_CLOSE,
    OP_CLEAR_VIEW,
    OP_EMIT_NORM,
    OP_EMIT_FUSED,
    OP_FUSE_INIT,
    OP_FUSE_CMP,
    OP_CLEAR_INST
  } dp_op_t;

  typedef struct packed {
    dp_op_t             op;
    logic [1:0]         axis;
    logic [MODEL_W-1:0] model;
    logic [VIEW_W-1:0]  view;
    logic               last;
  } dp_cmd_t;

  typedef struct packed {
    logic              active;
    logic              first;
    logic              mc_ok;
    logic              close;
    logic              inst_end;
    logic              consensus;
    logic              s_zero;
    logic              ws_zero;
    logic [VCNT_W-1:0] vc;
    logic              out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/msfc_dp.sv =====
module msfc_dp import msfc_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic [ID_W-1:0]             view_id,
  input  logic signed [POS_W-1:0]     pos_x,
  input  logic signed [POS_W-1:0]     pos_y,
  input  logic signed [POS_W-1:0]     pos_z,
  input  logic [SCORE_W-1:0]          score,
  input  logic                        last_model,
  input  logic                        last_view,
  input  dp_cmd_t                     cmd,
  output dp_status_t                  status,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [ID_W-1:0]             out_view_id,
  output logic [CLS_W-1:0]            class_index,
  output logic signed [POS_W-1:0]     out_pos_x,
  output logic signed [POS_W-1:0]     out_pos_y,
  output logic signed [POS_W-1:0]     out_pos_z,
  output logic                        last_of_run
);

  logic                 consensus;
  logic [SCORE_W-1:0]   thr [MAX_MODELS];

  logic [SUM_W-1:0]     sums [MAX_MODELS];
  logic [WSUM_W-1:0]    wsum;
  logic [WEIGHT_W-1:0]  vw;
  logic [VCNT_W-1:0]    vc;
  logic [MCNT_W-1:0]    mc;
  logic [CLS_W-1:0]     best_idx;
  logic [SCORE_W-1:0]   best_sc;

  logic [ID_W-1:0]      ids [MAX_VIEWS];
  logic [POS_W-1:0]     px [MAX_VIEWS];
  logic [POS_W-1:0]     py [MAX_VIEWS];
  logic [POS_W-1:0]     pz [MAX_VIEWS];

  logic signed [POS_W-1:0] it_px, it_py, it_pz;
  logic [SCORE_W-1:0]   it_score;
  logic                 it_close, it_end;

  logic [SQ_W-1:0]      s;
  logic [SUM_W-1:0]     div_q;
  logic [WSUM_W-1:0]    div_r;
  logic [WSUM_W-1:0]    div_d;
  logic [SUM_W-1:0]     rt_n, rt_root, rt_bit;
  logic [PROD_W-1:0]    prod;
  logic [SCORE_W-1:0]   fbest;
  logic [CLS_W-1:0]     emit_cls;
  logic [VIEW_W-1:0]    emit_slot;

  logic signed [POS_W-1:0] pos_sel;
  logic signed [SQ_W-1:0]  sq;
  logic [WSUM_W:0]         rem_sh;
  logic [WSUM_W:0]         rem_diff;
  logic [SUM_W-1:0]        trial;
  logic [SCORE_W-1:0]      f_sat;
  logic [MODEL_W-1:0]      mi;
  logic [VIEW_W-1:0]       slot;
  logic [VIEW_W-1:0]       rd;

  always_comb begin
    case (cmd.axis)
      2'd0:    pos_sel = it_px;
      2'd1:    pos_sel = it_py;
      default: pos_sel = it_pz;
    endcase
  end

  assign sq       = pos_sel * pos_sel;
  assign rem_sh   = {div_r, div_q[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, div_d};
  assign trial    = rt_root + rt_bit;
  assign f_sat    = (|div_q[SUM_W-1:SCORE_W]) ? '1 : div_q[SCORE_W-1:0];
  assign mi       = mc[MODEL_W-1:0];
  assign slot     = vc[VIEW_W-1:0];
  assign rd       = (cmd.op == OP_EMIT_FUSED) ? cmd.view : emit_slot;

  assign status.active    = vc < VCNT_W'(MAX_VIEWS);
  assign status.first     = mc == '0;
  assign status.mc_ok     = mc < MCNT_W'(MAX_MODELS);
  assign status.close     = it_close | it_end;
  assign status.inst_end  = it_end;
  assign status.consensus = consensus;
  assign status.s_zero    = s == '0;
  assign status.ws_zero   = wsum == '0;
  assign status.vc        = vc;
  assign status.out_free  = !out_valid || out_ready;

  // control state and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      consensus <= 1'b0;
      for (int i = 0; i < MAX_MODELS; i++) begin
        thr[i]  <= '0;
        sums[i] <= '0;
      end
      wsum      <= '0;
      vw        <= '0;
      vc        <= '0;
      mc        <= '0;
      best_idx  <= '0;
      best_sc   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_MODE) begin
          consensus <= cfg_data[0];
        end
        for (int i = 0; i < MAX_MODELS; i++) begin
          if (cfg_index == REG_THR0 + CFG_IDX_W'(i)) begin
            thr[i] <= cfg_data;
          end
        end
      end

      if (cmd.op == OP_EMIT_NORM || cmd.op == OP_EMIT_FUSED) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (cmd.op)
        OP_W_ZERO: vw <= '0;
        OP_W_ROOT: vw <= rt_root[WEIGHT_W-1:0];
        OP_ACC: begin
          sums[mi] <= sums[mi] + SUM_W'(prod);
          if (it_score >= thr[mi] && it_score > best_sc) begin
            best_sc  <= it_score;
            best_idx <= CLS_W'(mi) + CLS_W'(1);
          end
          mc <= mc + MCNT_W'(1);
        end
        OP_CLOSE: begin
          wsum     <= wsum + WSUM_W'(vw);
          vc       <= vc + VCNT_W'(1);
          mc       <= '0;
          best_idx <= '0;
          best_sc  <= '0;
          vw       <= '0;
        end
        OP_CLEAR_VIEW: begin
          mc       <= '0;
          best_idx <= '0;
          best_sc  <= '0;
          vw       <= '0;
        end
        OP_CLEAR_INST: begin
          for (int i = 0; i < MAX_MODELS; i++) begin
            sums[i] <= '0;
          end
          wsum     <= '0;
          vc       <= '0;
          mc       <= '0;
          best_idx <= '0;
          best_sc  <= '0;
          vw       <= '0;
        end
        default: ;
      endcase
    end
  end

  // payload, working registers and view store
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        it_px    <= pos_x;
        it_py    <= pos_y;
        it_pz    <= pos_z;
        it_score <= score;
        it_close <= last_model;
        it_end   <= last_view;
        s        <= '0;
        if (status.active && status.first) begin
          ids[slot] <= view_id;
          px[slot]  <= pos_x;
          py[slot]  <= pos_y;
          pz[slot]  <= pos_z;
        end
      end
      OP_SQ: s <= s + $unsigned(sq);
      OP_DIV_INIT_W: begin
        div_q <= W_DIVIDEND;
        div_r <= '0;
        div_d <= s;
      end
      OP_DIV_INIT_F: begin
        div_q <= sums[cmd.model];
        div_r <= '0;
        div_d <= wsum;
      end
      OP_DIV_STEP: begin
        if (rem_sh >= {1'b0, div_d}) begin
          div_r <= rem_diff[WSUM_W-1:0];
          div_q <= {div_q[SUM_W-2:0], 1'b1};
        end else begin
          div_r <= rem_sh[WSUM_W-1:0];
          div_q <= {div_q[SUM_W-2:0], 1'b0};
        end
      end
      OP_SQRT_INIT: begin
        rt_n    <= div_q;
        rt_root <= '0;
        rt_bit  <= SQRT_BIT0;
      end
      OP_SQRT_STEP: begin
        if (rt_n >= trial) begin
          rt_n    <= rt_n - trial;
          rt_root <= (rt_root >> 1) + rt_bit;
        end else begin
          rt_root <= rt_root >> 1;
        end
        rt_bit <= rt_bit >> 2;
      end
      OP_MUL: prod <= it_score * vw;
      OP_CLOSE: begin
        emit_slot <= slot;
        emit_cls  <= best_idx;
      end
      OP_FUSE_INIT: begin
        fbest    <= '0;
        emit_cls <= '0;
      end
      OP_FUSE_CMP: begin
        if (f_sat >= thr[cmd.model] && f_sat > fbest) begin
          fbest    <= f_sat;
          emit_cls <= CLS_W'(cmd.model) + CLS_W'(1);
        end
      end
      OP_EMIT_NORM, OP_EMIT_FUSED: begin
        out_view_id <= ids[rd];
        out_pos_x   <= px[rd];
        out_pos_y   <= py[rd];
        out_pos_z   <= pz[rd];
        class_index <= emit_cls;
        last_of_run <= (cmd.op == OP_EMIT_NORM) ? 1'b1 : cmd.last;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/msfc_ctrl.sv =====
module msfc_ctrl import msfc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_PREP  = 18'h00002,
    S_SQ    = 18'h00004,
    S_WCHK  = 18'h00008,
    S_WDIV  = 18'h00010,
    S_SQRTI = 18'h00020,
    S_SQRT  = 18'h00040,
    S_WSET  = 18'h00080,
    S_MUL   = 18'h00100,
    S_ACC   = 18'h00200,
    S_CLOSE = 18'h00400,
    S_EMITN = 18'h00800,
    S_END   = 18'h01000,
    S_FCHK  = 18'h02000,
    S_FDIV  = 18'h04000,
    S_FCMP  = 18'h08000,
    S_EMITF = 18'h10000,
    S_CLR   = 18'h20000
  } state_t;

  state_t             state, state_next;
  logic [STEP_W-1:0]  step, step_next;
  logic [MODEL_W-1:0] mdl, mdl_next;
  logic [VIEW_W-1:0]  view, view_next;
  logic               view_last;

  assign in_ready  = state == S_IDLE;
  assign view_last = (VCNT_W'(view) + VCNT_W'(1)) == status.vc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      mdl   <= '0;
      view  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      mdl   <= mdl_next;
      view  <= view_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    mdl_next   = mdl;
    view_next  = view;
    cmd        = '0;
    cmd.op     = OP_NONE;
    cmd.axis   = step[1:0];
    cmd.model  = mdl;
    cmd.view   = view;
    cmd.last   = view_last;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        step_next  = '0;
        state_next = (status.active && status.first) ? S_SQ : S_MUL;
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (step == STEP_W'(2)) begin
          step_next  = '0;
          state_next = S_WCHK;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_WCHK: begin
        if (status.s_zero) begin
          cmd.op     = OP_W_ZERO;
          state_next = S_MUL;
        end else begin
          cmd.op     = OP_DIV_INIT_W;
          step_next  = '0;
          state_next = S_WDIV;
        end
      end
      S_WDIV: begin
        cmd.op = OP_DIV_STEP;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          step_next  = '0;
          state_next = S_SQRTI;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_SQRTI: begin
        cmd.op     = OP_SQRT_INIT;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (step == STEP_W'(SQRT_STEPS - 1)) begin
          step_next  = '0;
          state_next = S_WSET;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_WSET: begin
        cmd.op     = OP_W_ROOT;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (status.active && status.mc_ok) begin
          cmd.op     = OP_MUL;
          state_next = S_ACC;
        end else begin
          state_next = S_CLOSE;
        end
      end
      S_ACC: begin
        cmd.op     = OP_ACC;
        state_next = S_CLOSE;
      end
      S_CLOSE: begin
        if (status.active && status.close) begin
          cmd.op     = OP_CLOSE;
          state_next = status.consensus ? S_END : S_EMITN;
        end else if (status.close) begin
          cmd.op     = OP_CLEAR_VIEW;
          state_next = S_END;
        end else begin
          state_next = S_END;
        end
      end
      S_EMITN: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.op     = OP_EMIT_NORM;
          state_next = S_END;
        end
      end
      S_END: begin
        if (!status.inst_end) begin
          state_next = S_IDLE;
        end else if (status.consensus && status.vc != '0) begin
          cmd.op     = OP_FUSE_INIT;
          mdl_next   = '0;
          state_next = S_FCHK;
        end else begin
          state_next = S_CLR;
        end
      end
      S_FCHK: begin
        // zero weight sum fuses every model to 0: nothing can win
        if (status.ws_zero) begin
          view_next  = '0;
          state_next = S_EMITF;
        end else begin
          cmd.op     = OP_DIV_INIT_F;
          step_next  = '0;
          state_next = S_FDIV;
        end
      end
      S_FDIV: begin
        cmd.op = OP_DIV_STEP;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          step_next  = '0;
          state_next = S_FCMP;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_FCMP: begin
        cmd.op = OP_FUSE_CMP;
        if (mdl == MODEL_W'(MAX_MODELS - 1)) begin
          view_next  = '0;
          state_next = S_EMITF;
        end else begin
          mdl_next   = mdl + MODEL_W'(1);
          state_next = S_FCHK;
        end
      end
      S_EMITF: begin
        if (status.out_free) begin
          cmd.op = OP_EMIT_FUSED;
          if (view_last) begin
            state_next = S_CLR;
          end else begin
            view_next = view + VIEW_W'(1);
          end
        end
      end
      S_CLR: begin
        cmd.op     = OP_CLEAR_INST;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/multiview_score_fusion_classifier_unit.sv =====
// Multiview score fusion classifier.
// Input channel (in_valid/in_ready): one word per model score of a view, model 0
// first; last_model closes the view, last_view closes the object instance.
// Output channel (out_valid/out_ready): one word per classified view. Normal
// mode gives one word when a view closes; consensus mode gives one word per
// stored view, in arrival order, at the close of the instance.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 consensus mode,
// indexes 1..4 the per-model reject thresholds. Write only while idle.
// A score that neither opens nor closes a view passes load, prep, multiply,
// accumulate, close and end; a close in normal mode adds an emit, a last
// view adds a clear. The first word of a view with nonzero position squares
// the three axes, then runs a 48-step restoring divider and a 24-step square
// root for its weight; with a zero position the weight is zero. A consensus
// close divides each model sum by the weight sum, then emits and clears.
// One word is in work at a time; in_ready is high only while idle.
// The output register holds a finished word while the next input is taken;
// a stalled receiver holds the block only when it has another word to emit.
// Synchronous reset clears configuration, accumulators, counters and
// the output valid; the view store has no reset.
module multiview_score_fusion_classifier_unit import msfc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ID_W-1:0]         view_id,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [SCORE_W-1:0]      score,
  input  logic                    last_model,
  input  logic                    last_view,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ID_W-1:0]         out_view_id,
  output logic [CLS_W-1:0]        class_index,
  output logic signed [POS_W-1:0] out_pos_x,
  output logic signed [POS_W-1:0] out_pos_y,
  output logic signed [POS_W-1:0] out_pos_z,
  output logic                    last_of_run
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  msfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  msfc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .view_id     (view_id),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .score       (score),
    .last_model  (last_model),
    .last_view   (last_view),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_view_id (out_view_id),
    .class_index (class_index),
    .out_pos_x   (out_pos_x),
    .out_pos_y   (out_pos_y),
    .out_pos_z   (out_pos_z),
    .last_of_run (last_of_run)
  );

endmodule

// ===== hw/rtl/msfc_checker.sv =====
module msfc_props import msfc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ID_W-1:0]  out_view_id,
  input logic [CLS_W-1:0] class_index
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(class_index) && $stable(out_view_id))
    else $error("output word changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in work");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> class_index <= CLS_W'(MAX_MODELS))
    else $error("class index out of range");

endmodule

bind multiview_score_fusion_classifier_unit msfc_props u_msfc_props (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_view_id (out_view_id),
  .class_index (class_index)
);

// ===== dv/msfc_checker.sv =====
`timescale 1ns / 1ps
module msfc_checker import msfc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [ID_W-1:0]         view_id,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [SCORE_W-1:0]      score,
  input  logic                    last_model,
  input  logic                    last_view,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [ID_W-1:0]         out_view_id,
  input  logic [CLS_W-1:0]        class_index,
  input  logic signed [POS_W-1:0] out_pos_x,
  input  logic signed [POS_W-1:0] out_pos_y,
  input  logic signed [POS_W-1:0] out_pos_z,
  input  logic                    last_of_run,
  output int                      errors,
  output int                      pending
);

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CLS_W-1:0] cls;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
    logic             last;
  } view_class_t;

  view_class_t class_q[$];

  logic                  fuse_en;
  logic [SCORE_W-1:0]    thr [MAX_MODELS];
  logic [SUM_W-1:0]      model_sum [MAX_MODELS];
  logic [WSUM_W-1:0]     wsum;
  logic [WEIGHT_W-1:0]   vweight;
  logic [ID_W-1:0]       seen_id [MAX_VIEWS];
  logic [POS_W-1:0]      seen_x [MAX_VIEWS];
  logic [POS_W-1:0]      seen_y [MAX_VIEWS];
  logic [POS_W-1:0]      seen_z [MAX_VIEWS];
  int                    vcount;
  int                    mcount;
  logic [CLS_W-1:0]      run_cls;
  logic [SCORE_W-1:0]    run_best;

  function automatic logic [WEIGHT_W-1:0] inv_dist(logic signed [POS_W-1:0] x,
                                                    logic signed [POS_W-1:0] y,
                                                    logic signed [POS_W-1:0] z);
    longint sq;
    longint unsigned q;
    longint unsigned r;
    longint unsigned t;
    sq = longint'(x) * x + longint'(y) * y + longint'(z) * z;
    if (sq == 0) return '0;
    q = (64'd1 << 46) / longint'(sq);
    r = 0;
    for (int b = 23; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= q) r = t;
    end
    return r[WEIGHT_W-1:0];
  endfunction

  function automatic void push_class(int slot, logic [CLS_W-1:0] cls, logic last);
    view_class_t e;
    e.id = seen_id[slot];
    e.cls = cls;
    e.x = seen_x[slot];
    e.y = seen_y[slot];
    e.z = seen_z[slot];
    e.last = last;
    class_q = {class_q, e};
  endfunction

  function automatic void clear_view();
    mcount = 0;
    run_cls = '0;
    run_best = '0;
    vweight = '0;
  endfunction

  function automatic void classify_word();
    logic closing;
    longint unsigned f;
    longint unsigned fbest;
    logic [CLS_W-1:0] fcls;
    closing = last_model | last_view;
    if (vcount < MAX_VIEWS) begin
      if (mcount == 0) begin
        vweight = inv_dist(pos_x, pos_y, pos_z);
        seen_id[vcount] = view_id;
        seen_x[vcount] = pos_x;
        seen_y[vcount] = pos_y;
        seen_z[vcount] = pos_z;
      end
      if (mcount < MAX_MODELS) begin
        model_sum[mcount] = model_sum[mcount] + SUM_W'(score) * vweight;
        if (score >= thr[mcount] && score > run_best) begin
          run_best = score;
          run_cls = CLS_W'(mcount + 1);
        end
        mcount++;
      end
      if (closing) begin
        wsum = wsum + vweight;
        vcount++;
        if (!fuse_en) push_class(vcount - 1, run_cls, 1'b1);
        clear_view();
      end
    end else if (closing) begin
      clear_view();
    end
    if (last_view) begin
      if (fuse_en && vcount > 0) begin
        fbest = 0;
        fcls = '0;
        for (int m = 0; m < MAX_MODELS; m++) begin
          f = (wsum != 0) ? model_sum[m] / wsum : 0;
          if (f > 65535) f = 65535;
          if (f >= thr[m] && f > fbest) begin
            fbest = f;
            fcls = CLS_W'(m + 1);
          end
        end
        for (int v = 0; v < vcount; v++) push_class(v, fcls, v + 1 == vcount);
      end
      for (int m = 0; m < MAX_MODELS; m++) model_sum[m] = '0;
      vcount = 0;
      wsum = '0;
      clear_view();
    end
  endfunction

  always @(posedge clk) begin
    view_class_t exp_v;
    if (rst) begin
      fuse_en = 1'b0;
      for (int m = 0; m < MAX_MODELS; m++) begin
        thr[m] = '0;
        model_sum[m] = '0;
      end
      wsum = '0;
      vcount = 0;
      clear_view();
      class_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MODE) fuse_en = cfg_data[0];
        else if (cfg_index >= REG_THR0 && cfg_index < REG_THR0 + MAX_MODELS)
          thr[cfg_index - REG_THR0] = cfg_data;
      end
      // compare before predicting: a word out now was caused by an earlier input
      if (out_valid && out_ready) begin
        if (class_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: view %0d class %0d", out_view_id,
                                     class_index);
        end else begin
          exp_v = class_q.pop_front();
          if (exp_v.id !== out_view_id || exp_v.cls !== class_index ||
              exp_v.x !== out_pos_x || exp_v.y !== out_pos_y ||
              exp_v.z !== out_pos_z || exp_v.last !== last_of_run) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp id %0d cls %0d pos %h %h %h last %b, got %0d %0d %h %h %h %b",
                       exp_v.id, exp_v.cls, exp_v.x, exp_v.y, exp_v.z, exp_v.last,
                       out_view_id, class_index, out_pos_x, out_pos_y, out_pos_z,
                       last_of_run);
          end
        end
      end
      if (in_valid && in_ready) classify_word();
    end
    pending = class_q.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb import msfc_pkg::*;;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(REG_THR0 + MAX_MODELS);

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready;
  logic [ID_W-1:0] view_id;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic [SCORE_W-1:0] score;
  logic last_model, last_view;
  logic out_valid, out_ready;
  logic [ID_W-1:0] out_view_id;
  logic [CLS_W-1:0] class_index;
  logic signed [POS_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic last_of_run;
  int errors, pending;
  int words_sent;

  multiview_score_fusion_classifier_unit u_dut (.*);

  msfc_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver: stalls of random length, with long always-ready stretches
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 9) == 0) begin
        out_ready = 1'b1;
        repeat ($urandom_range(50, 200)) @(negedge clk);
      end else begin
        n = gap_len();
        out_ready = (n == 0);
        repeat (n) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // let the last close and any divider work finish before touching registers
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic set_thresholds(int t0, int t1, int t2, int t3);
    write_reg(REG_THR0, CFG_DATA_W'(t0));
    write_reg(REG_THR0 + CFG_IDX_W'(1), CFG_DATA_W'(t1));
    write_reg(REG_THR0 + CFG_IDX_W'(2), CFG_DATA_W'(t2));
    write_reg(REG_THR0 + CFG_IDX_W'(3), CFG_DATA_W'(t3));
  endtask

  task automatic send_word(logic [ID_W-1:0] id, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                           logic [POS_W-1:0] z, logic [SCORE_W-1:0] sc,
                           logic lm, logic lv, bit gaps);
    if (gaps) begin
      in_valid = 1'b0;
      repeat (gap_len()) @(negedge clk);
    end
    in_valid = 1'b1;
    view_id = id;
    pos_x = x;
    pos_y = y;
    pos_z = z;
    score = sc;
    last_model = lm;
    last_view = lv;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    words_sent++;
  endtask

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return POS_W'($urandom_range(0, 15) - 8);
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic logic [SCORE_W-1:0] rand_score();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'hffff;
      default: return SCORE_W'($urandom);
    endcase
  endfunction

  // one object instance: well formed, random content, sometimes extra models or views
  task automatic send_instance(int nviews);
    int nm;
    logic [POS_W-1:0] x, y, z;
    logic [ID_W-1:0] id;
    for (int v = 0; v < nviews; v++) begin
      nm = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : MAX_MODELS;
      x = rand_pos();
      y = rand_pos();
      z = rand_pos();
      id = ID_W'($urandom);
      for (int m = 0; m < nm; m++) begin
        // later words of a view carry junk ids/positions: only the first is latched
        if (m == 0) send_word(id, x, y, z, rand_score(), m == nm - 1,
                              (v == nviews - 1) && (m == nm - 1), 1'b1);
        else send_word(ID_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                       POS_W'($urandom), rand_score(),
                       (m == nm - 1) && (v != nviews - 1 || $urandom_range(0, 3) != 0),
                       (v == nviews - 1) && (m == nm - 1), 1'b1);
      end
    end
  endtask

  initial begin
    int goal;
    int nv;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    view_id = '0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    score = '0;
    last_model = 1'b0;
    last_view = 1'b0;
    words_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: normal mode, zero thresholds
    write_reg(REG_MODE, 0);
    set_thresholds(0, 0, 0, 0);
    write_reg(REG_SPARE, 16'hffff);
    // tie on equal scores keeps model 0; zero scores reject
    send_word(3'd7, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'h1234, 0, 0, 0);
    send_word(3'd0, 0, 0, 0, 16'h1234, 0, 0, 0);
    send_word(3'd0, 0, 0, 0, 16'hffff, 0, 0, 0);
    send_word(3'd0, 0, 0, 0, 16'h0000, 1, 0, 0);
    send_word(3'd2, 0, 0, 0, 16'h0000, 1, 0, 0);
    // extra models past the fourth are ignored; last view without last model
    send_word(3'd5, 16'sh8000, 16'sh8000, 16'sh8000, 16'h0001, 0, 0, 0);
    repeat (5) send_word(3'd1, 1, 1, 1, 16'hffff, 0, 0, 0);
    send_word(3'd1, 1, 1, 1, 16'hffff, 0, 1, 0);
    drain();
    // extra views past eight: no result, last view still ends the instance
    for (int v = 0; v < 10; v++)
      send_word(ID_W'(v), POS_W'(v), POS_W'(-v), 1, SCORE_W'(16'h8000 + v), 1, v == 9, 0);
    drain();

    // consensus mode, thresholds at top, then zero-position weights
    write_reg(REG_MODE, 1);
    set_thresholds(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_instance(3);
    drain();
    set_thresholds(0, 0, 0, 0);
    send_word(3'd4, 0, 0, 0, 16'hffff, 1, 0, 0);
    send_word(3'd6, 0, 0, 0, 16'hffff, 0, 1, 0);
    drain();
    send_word(3'd3, 1, 0, 0, 16'hffff, 1, 1, 0);
    drain();

    // mode change mid instance: views emitted in normal mode are fused again
    write_reg(REG_MODE, 0);
    send_word(3'd2, 100, 200, 300, 16'h4000, 0, 0, 0);
    send_word(3'd2, 0, 0, 0, 16'h9000, 1, 0, 0);
    drain();
    write_reg(REG_MODE, 1);
    send_word(3'd5, -5, 7, 9, 16'h2000, 0, 0, 0);
    send_word(3'd5, 0, 0, 0, 16'h1000, 0, 1, 0);
    drain();

    // random phases across settings
    goal = words_sent + 170;
    for (int ph = 0; words_sent < goal; ph++) begin
      write_reg(REG_MODE, CFG_DATA_W'(ph[0]));
      case (ph % 4)
        0: set_thresholds(0, 0, 0, 0);
        1: set_thresholds(16'hffff, 0, 16'hffff, 0);
        default: set_thresholds($urandom_range(0, 40000), $urandom_range(0, 40000),
                                $urandom_range(0, 40000), $urandom_range(0, 40000));
      endcase
      write_reg(REG_SPARE, CFG_DATA_W'($urandom));
      for (int k = 0; k < 6 && words_sent < goal; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise word with random flags
          send_word(ID_W'($urandom), POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                    SCORE_W'($urandom), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b1);
        end else begin
          nv = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 4);
          send_instance(nv);
        end
        if (k == 2) while (pending != 0) @(negedge clk);
      end
      // close any instance a noise word left open
      send_word(ID_W'($urandom), POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                SCORE_W'($urandom), 1, 1, 1'b1);
      drain();
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
